[sv/positional_list_store_top_defines.svh]
// Assertion macros shared by the list store RTL
`ifndef POSITIONAL_LIST_STORE_TOP_DEFINES_SVH
`define POSITIONAL_LIST_STORE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define PLS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("list store check failed");

// Next-cycle implication, sampled on clk, off during reset
`define PLS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("list store check failed");

`endif

[sv/pls_pkg.sv]
// Types and constants of the positional list store
package pls_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int POS_W    = 5;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_READ   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_BAD_POS = 2'd2
  } status_t;

  // Result of one operation while the memory read is in flight
  typedef struct packed {
    logic             is_read;
    logic [CNT_W-1:0] count;
    status_t          status;
  } rslt_t;

endpackage

[sv/positional_list_store_top.sv]
// Positional list store: ordered list of signed 32-bit values
//
// The list keeps up to CAPACITY values in order. Values live in a single
// memory with a registered read; a register file of slot numbers
// (one per list position) gives the order, and insert or remove shifts that
// map by one place while the value itself is written once.
// One operation is taken per cycle while the input is not stalled; its result
// beat is registered in stage one (beside the memory read) and then in the
// output register, and the input stalls only when both of those stages are held by
// back-pressure on the output. After reset the list is empty and an operation
// may be sent at once; no memory clearing pass is needed.
module positional_list_store_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        kind,
  input  logic signed [pls_pkg::VAL_W-1:0]  value,
  input  logic [pls_pkg::POS_W-1:0]         position,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [pls_pkg::VAL_W-1:0]  read_value,
  output logic [pls_pkg::POS_W-1:0]         element_count,
  output logic [1:0]                        status
);
  import pls_pkg::*;

  // Value memory and its read register
  logic [VAL_W-1:0] mem [CAPACITY];
  logic [VAL_W-1:0] rd_data;

  // Order map: slot number held at each list position; entries at and past
  // count hold the free slots
  logic [IDX_W-1:0] order      [CAPACITY];
  logic [IDX_W-1:0] order_next [CAPACITY];
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  // Pipeline registers
  logic  s1_valid;
  rslt_t s1;
  rslt_t s1_next;
  logic  out_is_read;
  logic [CNT_W-1:0] out_count;
  status_t out_status;

  logic in_fire, s1_move;
  logic is_add, full, bad;
  logic do_add, do_rem, do_rd;
  logic [CMP_W-1:0] pos_c, cnt_c, slot, rem_at;
  logic [IDX_W-1:0] sel_idx, phys;

  // Handshake: stage one drains into the output register when it is free
  assign s1_move  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_move;
  assign in_fire  = in_valid && in_ready;

  // Decode and range checks
  always_comb begin
    pos_c   = CMP_W'(position);
    cnt_c   = CMP_W'(count);
    is_add  = (kind == KIND_APPEND) || (kind == KIND_INSERT);
    full    = (count == CNT_W'(CAPACITY));
    bad     = (pos_c == '0) || (pos_c > cnt_c);
    slot    = ((kind == KIND_INSERT) && (pos_c < cnt_c)) ? pos_c : cnt_c;
    rem_at  = pos_c - CMP_W'(1);
    sel_idx = is_add ? IDX_W'(count) : IDX_W'(rem_at);
    phys    = order[sel_idx];
    do_add  = in_fire && is_add && !full;
    do_rem  = in_fire && (kind == KIND_REMOVE) && !bad;
    do_rd   = in_fire && (kind == KIND_READ) && !bad;
  end

  // Order map shift and count update
  always_comb begin
    count_next = count;
    for (int i = 0; i < CAPACITY; i++) begin
      order_next[i] = order[i];
      if (do_add) begin
        if (CMP_W'(i) == slot) begin
          order_next[i] = phys;
        end else if ((CMP_W'(i) > slot) && (CMP_W'(i) <= cnt_c)) begin
          order_next[i] = order[IDX_W'(i - 1)];
        end
      end else if (do_rem) begin
        if ((CMP_W'(i) >= rem_at) && (CMP_W'(i + 1) < cnt_c)) begin
          order_next[i] = order[IDX_W'(i + 1)];
        end else if (CMP_W'(i + 1) == cnt_c) begin
          order_next[i] = phys;
        end
      end
    end
    if (do_add) begin
      count_next = count + CNT_W'(1);
    end else if (do_rem) begin
      count_next = count - CNT_W'(1);
    end
  end

  // Result of the accepted operation
  always_comb begin
    s1_next.is_read = do_rd;
    s1_next.count   = count_next;
    if (is_add && full) begin
      s1_next.status = STATUS_FULL;
    end else if (!is_add && bad) begin
      s1_next.status = STATUS_BAD_POS;
    end else begin
      s1_next.status = STATUS_OK;
    end
  end

  // Value memory: write on append or insert, registered read on read
  always_ff @(posedge clk) begin
    if (do_add) begin
      mem[phys] <= value;
    end
    if (do_rd) begin
      rd_data <= mem[phys];
    end
  end

  // Map and count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      for (int i = 0; i < CAPACITY; i++) begin
        order[i] <= IDX_W'(i);
      end
    end else begin
      count <= count_next;
      order <= order_next;
    end
  end

  // Stage one and output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1 <= s1_next;
    end
    if (s1_move) begin
      out_is_read <= s1.is_read;
      out_count   <= s1.count;
      out_status  <= s1.status;
      read_value  <= s1.is_read ? rd_data : '0;
    end
  end

  assign element_count = POS_W'(out_count);
  assign status        = out_status;

  // Checks
`include "positional_list_store_top_defines.svh"

  `PLS_ASSERT_SAME(a_count_bound, 1'b1, count <= CNT_W'(CAPACITY))
  `PLS_ASSERT_NEXT(a_full_holds, in_fire && is_add && full, count == CNT_W'(CAPACITY))
  `PLS_ASSERT_NEXT(a_remove_dec, do_rem, count == $past(count) - CNT_W'(1))
  `PLS_ASSERT_SAME(a_stall_in, s1_valid && out_valid && !out_ready, !in_ready)
  `PLS_ASSERT_SAME(a_read_ok, out_valid && out_is_read, out_status == STATUS_OK)

endmodule

[tb/testbench.sv]
// Testbench for positional_list_store_top: directed table plus random list traffic
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pls_pkg::*;

  // One result beat as the block reports it
  typedef struct packed {
    logic signed [VAL_W-1:0] rv;
    logic [POS_W-1:0]        cnt;
    status_t                 st;
  } list_result_t;

  // One row of the directed table; want is used only when fixed is set
  typedef struct packed {
    kind_t              k;
    logic [VAL_W-1:0]   v;
    logic [POS_W-1:0]   p;
    logic [POS_W-1:0]   reps;
    logic               fixed;
    list_result_t       want;
  } stim_row_t;

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_ready;
  logic [1:0]              kind;
  logic signed [VAL_W-1:0] value;
  logic [POS_W-1:0]        position;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [VAL_W-1:0] read_value;
  logic [POS_W-1:0]        element_count;
  logic [1:0]              status;

  // Shadow copy of the list
  logic signed [VAL_W-1:0] list_vals [0:CAPACITY-1];
  int                      list_len;

  list_result_t            pending_results[$];
  stim_row_t               directed_rows[$];
  int                      errors;
  int                      in_idle_pct;
  int                      out_idle_pct;

  positional_list_store_top u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .value         (value),
    .position      (position),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .read_value    (read_value),
    .element_count (element_count),
    .status        (status)
  );

  // 8 ns clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Apply one operation to the shadow list and return its result
  function automatic list_result_t apply_list_op(kind_t k, logic signed [VAL_W-1:0] v,
                                                 logic [POS_W-1:0] p);
    list_result_t r;
    int           slot;
    int           i;
    r.rv = '0;
    r.st = STATUS_OK;
    if (k == KIND_APPEND || k == KIND_INSERT) begin
      if (list_len >= CAPACITY) begin
        r.st = STATUS_FULL;
      end else begin
        slot = list_len;
        if (k == KIND_INSERT && int'(p) < list_len) slot = int'(p);
        for (i = list_len; i > slot; i--) list_vals[i] = list_vals[i-1];
        list_vals[slot] = v;
        list_len++;
      end
    end else begin
      if (p == 0 || int'(p) > list_len) begin
        r.st = STATUS_BAD_POS;
      end else if (k == KIND_REMOVE) begin
        for (i = int'(p) - 1; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
        list_len--;
      end else begin
        r.rv = list_vals[int'(p) - 1];
      end
    end
    r.cnt = list_len[POS_W-1:0];
    return r;
  endfunction

  task automatic add_row(kind_t k, logic [VAL_W-1:0] v, logic [POS_W-1:0] p,
                         logic [POS_W-1:0] reps, logic fixed, logic [POS_W-1:0] cnt,
                         status_t st);
    stim_row_t row;
    row.k        = k;
    row.v        = v;
    row.p        = p;
    row.reps     = reps;
    row.fixed    = fixed;
    row.want.rv  = '0;
    row.want.cnt = cnt;
    row.want.st  = st;
    directed_rows.push_back(row);
  endtask

  // Drive one input beat from a falling edge; returns at the falling edge after acceptance
  task automatic send_op(kind_t k, logic [VAL_W-1:0] v, logic [POS_W-1:0] p,
                         logic fixed, list_result_t want);
    list_result_t predicted;
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    value    <= v;
    position <= p;
    do @(posedge clk); while (in_ready !== 1'b1);
    predicted = apply_list_op(k, v, p);
    pending_results.push_back(fixed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic check_field(string name, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // Result beat checker
  always @(posedge clk) begin
    list_result_t exp_r;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected result beat, expected none, actual %h/%0d/%0d",
                 $time, read_value, element_count, status);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("read_value", exp_r.rv, read_value);
        check_field("element_count", {27'b0, exp_r.cnt}, {27'b0, element_count});
        check_field("status", {30'b0, exp_r.st}, {30'b0, status});
      end
    end
  end

  // Output back-pressure in random bursts
  initial begin
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if ($urandom_range(99) < out_idle_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // Stimulus
  initial begin
    stim_row_t    row;
    list_result_t no_want;
    kind_t        k;
    logic [VAL_W-1:0] v;
    logic [POS_W-1:0] p;
    int           n;
    int           r;
    bit           filling;

    rst          = 1'b1;
    in_valid     = 1'b0;
    kind         = KIND_APPEND;
    value        = '0;
    position     = '0;
    errors       = 0;
    list_len     = 0;
    in_idle_pct  = 20;
    out_idle_pct = 20;
    no_want      = '0;
    filling      = 1'b1;
    for (n = 0; n < CAPACITY; n++) list_vals[n] = '0;

    // Empty list, extremes, front and past-end inserts, bad indexes, full list
    add_row(KIND_READ,   32'h0,        5'd1,  5'd1,  1'b1, 5'd0,  STATUS_BAD_POS);
    add_row(KIND_REMOVE, 32'h0,        5'd0,  5'd1,  1'b1, 5'd0,  STATUS_BAD_POS);
    add_row(KIND_REMOVE, 32'hFFFFFFFF, 5'd31, 5'd1,  1'b1, 5'd0,  STATUS_BAD_POS);
    add_row(KIND_APPEND, 32'h7FFFFFFF, 5'd0,  5'd1,  1'b1, 5'd1,  STATUS_OK);
    add_row(KIND_APPEND, 32'h80000000, 5'd31, 5'd1,  1'b1, 5'd2,  STATUS_OK);
    add_row(KIND_INSERT, 32'hFFFFFFFF, 5'd0,  5'd1,  1'b1, 5'd3,  STATUS_OK);
    add_row(KIND_INSERT, 32'h00000000, 5'd31, 5'd1,  1'b1, 5'd4,  STATUS_OK);
    add_row(KIND_READ,   32'h0,        5'd1,  5'd1,  1'b0, 5'd0,  STATUS_OK);
    add_row(KIND_READ,   32'h0,        5'd2,  5'd1,  1'b0, 5'd0,  STATUS_OK);
    add_row(KIND_READ,   32'h0,        5'd4,  5'd1,  1'b0, 5'd0,  STATUS_OK);
    add_row(KIND_READ,   32'h0,        5'd0,  5'd1,  1'b1, 5'd4,  STATUS_BAD_POS);
    add_row(KIND_READ,   32'h0,        5'd5,  5'd1,  1'b1, 5'd4,  STATUS_BAD_POS);
    add_row(KIND_INSERT, 32'h55555555, 5'd2,  5'd1,  1'b0, 5'd0,  STATUS_OK);
    add_row(KIND_REMOVE, 32'h0,        5'd5,  5'd1,  1'b0, 5'd0,  STATUS_OK);
    add_row(KIND_REMOVE, 32'h0,        5'd1,  5'd1,  1'b0, 5'd0,  STATUS_OK);
    add_row(KIND_APPEND, 32'hAAAAAAAA, 5'd0,  5'd13, 1'b0, 5'd0,  STATUS_OK);
    add_row(KIND_APPEND, 32'h12345678, 5'd0,  5'd1,  1'b1, 5'd16, STATUS_FULL);
    add_row(KIND_INSERT, 32'h87654321, 5'd0,  5'd1,  1'b1, 5'd16, STATUS_FULL);
    add_row(KIND_READ,   32'h0,        5'd16, 5'd1,  1'b0, 5'd0,  STATUS_OK);
    add_row(KIND_READ,   32'h0,        5'd17, 5'd1,  1'b1, 5'd16, STATUS_BAD_POS);
    add_row(KIND_REMOVE, 32'h0,        5'd16, 5'd1,  1'b0, 5'd0,  STATUS_OK);
    add_row(KIND_INSERT, 32'h0F0F0F0F, 5'd7,  5'd1,  1'b0, 5'd0,  STATUS_OK);
    add_row(KIND_REMOVE, 32'h0,        5'd1,  5'd16, 1'b0, 5'd0,  STATUS_OK);
    add_row(KIND_READ,   32'h0,        5'd1,  5'd1,  1'b1, 5'd0,  STATUS_BAD_POS);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      repeat (row.reps) send_op(row.k, row.v, row.p, row.fixed, row.want);
    end

    // Random traffic: fill and drain sweeps with some noise
    for (n = 0; n < 1100; n++) begin
      if (n % 100 == 0) begin
        case ($urandom_range(2))
          0: in_idle_pct = 0;
          1: in_idle_pct = 10;
          default: in_idle_pct = 35;
        endcase
        case ($urandom_range(2))
          0: out_idle_pct = 0;
          1: out_idle_pct = 10;
          default: out_idle_pct = 35;
        endcase
      end
      if (n >= 950) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end

      if (list_len == CAPACITY && $urandom_range(3) == 0) filling = 1'b0;
      if (list_len == 0) filling = 1'b1;
      if ($urandom_range(49) == 0) filling = !filling;

      r = $urandom_range(99);
      if (filling) begin
        if (r < 25)      k = KIND_APPEND;
        else if (r < 60) k = KIND_INSERT;
        else if (r < 85) k = KIND_READ;
        else             k = KIND_REMOVE;
      end else begin
        if (r < 10)      k = KIND_APPEND;
        else if (r < 25) k = KIND_INSERT;
        else if (r < 55) k = KIND_READ;
        else             k = KIND_REMOVE;
      end

      // Positions mostly in range, sometimes anywhere in the field
      if (k == KIND_APPEND || k == KIND_INSERT) begin
        if ($urandom_range(9) == 0) p = POS_W'($urandom_range(31));
        else                        p = POS_W'($urandom_range(list_len, 0));
      end else begin
        if (list_len == 0 || $urandom_range(9) == 0) p = POS_W'($urandom_range(31));
        else                                         p = POS_W'($urandom_range(list_len, 1));
      end

      case ($urandom_range(9))
        0: v = 32'h7FFFFFFF;
        1: v = 32'h80000000;
        default: v = $urandom;
      endcase

      // Noise beat
      if ($urandom_range(99) < 8) begin
        k = kind_t'($urandom_range(3));
        p = POS_W'($urandom_range(31));
      end

      send_op(k, v, p, 1'b0, no_want);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("positional_list_store_top test passed");
    end else begin
      $display("positional_list_store_top test failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2000000;
    $display("positional_list_store_top test failed");
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/pls_pkg.sv
sv/positional_list_store_top.sv
tb/testbench.sv
